[hw/rtl/kdm_pkg.sv]
`default_nettype none

package kdm_pkg;

    // default sizing of the matcher
    localparam int MAX_PATTERN_DEF   = 32;
    localparam int ALPHABET_DEF      = 256;
    localparam int POSITION_BITS_DEF = 16;

    // entries in the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // item opcodes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // input transaction payload
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic        match_found;
        logic [15:0] match_start;
    } t_out_item;

    // classified command held in the queue
    typedef struct packed {
        t_opcode    op;
        logic [7:0] sym;
    } t_cmd;

    // back part sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ZERO,
        BK_RESTART,
        BK_COPY
    } t_back_state;

endpackage

`default_nettype wire

[hw/rtl/kdm_ram.sv]
`default_nettype none

module kdm_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/kdm_front.sv]
`default_nettype none

module kdm_front #(
    parameter int ALPHABET = kdm_pkg::ALPHABET_DEF
) (
    input  wire logic              i_start,
    input  wire kdm_pkg::t_in_item i_item,
    input  wire logic              i_full,
    output logic                   o_push,
    output kdm_pkg::t_cmd          o_cmd
);

    import kdm_pkg::*;

    // reciprocal of the alphabet size scaled by 2^16, exact for every byte value
    localparam int RECIP = (65536 + ALPHABET - 1) / ALPHABET;

    // byte modulo alphabet size by reciprocal multiplication
    function automatic logic [7:0] reduce_sym(input logic [7:0] b);
        logic [24:0] prod;
        logic [16:0] quot_a;
        logic [16:0] rem;
        prod   = 25'(b) * 25'(RECIP);
        quot_a = 17'(prod[24:16]) * 17'(ALPHABET);
        rem    = 17'(b) - quot_a;
        return rem[7:0];
    endfunction

    // accept, drop unused opcode, classify and reduce the byte
    always_comb begin
        o_push    = i_start && !i_full && (i_item.opcode != OP_NOP);
        o_cmd.op  = t_opcode'(i_item.opcode);
        o_cmd.sym = reduce_sym(i_item.byte_value);
    end

endmodule

`default_nettype wire

[hw/rtl/kdm_fifo.sv]
`default_nettype none

module kdm_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire kdm_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output kdm_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    import kdm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // pointer advance with wrap
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

`default_nettype wire

[hw/rtl/kdm_back.sv]
`default_nettype none

module kdm_back #(
    parameter int MAX_PATTERN   = kdm_pkg::MAX_PATTERN_DEF,
    parameter int ALPHABET      = kdm_pkg::ALPHABET_DEF,
    parameter int POSITION_BITS = kdm_pkg::POSITION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kdm_pkg::t_cmd i_cmd,
    input  wire logic          i_valid,
    output logic               o_pop,
    output logic               o_result_strobe,
    output kdm_pkg::t_out_item o_result
);

    import kdm_pkg::*;

    localparam int ROW_COUNT = MAX_PATTERN + 1;
    localparam int ST_W      = $clog2(ROW_COUNT);
    localparam int SYM_W     = $clog2(ALPHABET);
    localparam int AW        = ST_W + SYM_W;
    localparam int DEPTH     = ROW_COUNT * (2 ** SYM_W);
    localparam int POS_W     = POSITION_BITS;
    localparam int CMP_W     = (POS_W > ST_W) ? POS_W : ST_W;

    t_back_state r_state, n_state;
    logic [ST_W-1:0]  r_len, n_len;
    logic [ST_W-1:0]  r_restart, n_restart;
    logic [ST_W-1:0]  r_cur, n_cur;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [SYM_W-1:0] r_sym, n_sym;
    logic [SYM_W-1:0] r_col, n_col;
    logic [ST_W-1:0]  r_src, n_src;
    logic [ST_W-1:0]  r_dst, n_dst;
    logic             r_issue, n_issue;
    logic             r_wr_on, n_wr_on;
    logic [SYM_W-1:0] r_wr_col, n_wr_col;
    logic             r_pend, n_pend;
    logic             r_pend_chk, n_pend_chk;
    logic [ST_W-1:0]  r_pend_len, n_pend_len;
    logic [POS_W-1:0] r_pend_start, n_pend_start;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ST_W-1:0]  ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [ST_W-1:0]  ram_rdata;

    logic [ST_W-1:0]     cur_fwd;
    logic [SYM_W-1:0]    cmd_sym;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    back_ext;
    logic [CMP_W-1:0]    start_full;
    logic                found;
    logic [POS_W-1:0]    start_pos;
    logic [POS_W+15:0]   start_wide;

    // transition table, one row per automaton state
    kdm_ram #(
        .WIDTH (ST_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_len       <= '0;
            r_restart   <= '0;
            r_cur       <= '0;
            r_pos       <= '0;
            r_issue     <= 1'b0;
            r_wr_on     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_restart   <= n_restart;
            r_cur       <= n_cur;
            r_pos       <= n_pos;
            r_issue     <= n_issue;
            r_wr_on     <= n_wr_on;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_col        <= n_col;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_wr_col     <= n_wr_col;
        r_pend_chk   <= n_pend_chk;
        r_pend_len   <= n_pend_len;
        r_pend_start <= n_pend_start;
        r_out        <= n_out;
    end

    // start position of an occurrence ending at the current byte
    always_comb begin
        pos_ext    = CMP_W'(r_pos);
        back_ext   = CMP_W'(r_len) - CMP_W'(1);
        start_full = (pos_ext >= back_ext) ? (pos_ext - back_ext) : '0;
    end

    // result of the lookup issued in the previous cycle
    always_comb begin
        cur_fwd    = (r_pend && r_pend_chk) ? ram_rdata : r_cur;
        found      = r_pend && r_pend_chk && (ram_rdata == r_pend_len);
        start_pos  = found ? r_pend_start : '0;
        start_wide = {16'd0, start_pos};
    end

    assign cmd_sym = i_cmd.sym[SYM_W-1:0];

    // sequencer: next state, table port control
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_restart    = r_restart;
        n_cur        = r_cur;
        n_pos        = r_pos;
        n_sym        = r_sym;
        n_col        = r_col;
        n_src        = r_src;
        n_dst        = r_dst;
        n_issue      = r_issue;
        n_wr_on      = 1'b0;
        n_wr_col     = r_wr_col;
        n_pend       = 1'b0;
        n_pend_chk   = r_pend_chk;
        n_pend_len   = r_pend_len;
        n_pend_start = r_pend_start;
        o_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        // finish a pending text lookup
        n_out_valid           = r_pend;
        n_out.match_found     = found;
        n_out.match_start     = start_wide[15:0];
        if (r_pend && r_pend_chk) begin
            n_cur = ram_rdata;
        end

        case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_len     = '0;
                            n_restart = '0;
                            n_cur     = '0;
                            n_pos     = '0;
                        end
                        OP_APPEND: begin
                            if (r_len == ST_W'(MAX_PATTERN)) begin
                                // pattern full, ignore
                                n_state = BK_IDLE;
                            end else if (r_len == '0) begin
                                // first byte rebuilds the whole start row
                                n_sym   = cmd_sym;
                                n_col   = '0;
                                n_state = BK_ZERO;
                            end else begin
                                // forward edge, and look up the new restart state
                                ram_we    = 1'b1;
                                ram_waddr = {r_len, cmd_sym};
                                ram_wdata = r_len + ST_W'(1);
                                ram_re    = 1'b1;
                                ram_raddr = {r_restart, cmd_sym};
                                n_dst     = r_len + ST_W'(1);
                                n_state   = BK_RESTART;
                            end
                        end
                        OP_TEXT: begin
                            n_pend       = 1'b1;
                            n_pend_chk   = (r_len != '0);
                            n_pend_len   = r_len;
                            n_pend_start = start_full[POS_W-1:0];
                            if (r_len != '0) begin
                                ram_re    = 1'b1;
                                ram_raddr = {cur_fwd, cmd_sym};
                            end else begin
                                n_cur = '0;
                            end
                            if (r_pos != {POS_W{1'b1}}) begin
                                n_pos = r_pos + POS_W'(1);
                            end
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_ZERO: begin
                // start row: only the first pattern byte leaves state zero
                ram_we    = 1'b1;
                ram_waddr = {ST_W'(0), r_col};
                ram_wdata = (r_col == r_sym) ? ST_W'(1) : '0;
                if (r_col == SYM_W'(ALPHABET - 1)) begin
                    n_len   = ST_W'(1);
                    n_src   = '0;
                    n_dst   = ST_W'(1);
                    n_col   = '0;
                    n_issue = 1'b1;
                    n_state = BK_COPY;
                end else begin
                    n_col = r_col + SYM_W'(1);
                end
            end
            BK_RESTART: begin
                n_restart = ram_rdata;
                n_src     = ram_rdata;
                n_len     = r_dst;
                n_col     = '0;
                n_issue   = 1'b1;
                n_state   = BK_COPY;
            end
            BK_COPY: begin
                // read restart row one column ahead of the write into the final row
                if (r_issue) begin
                    ram_re    = 1'b1;
                    ram_raddr = {r_src, r_col};
                    if (r_col == SYM_W'(ALPHABET - 1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_col = r_col + SYM_W'(1);
                    end
                end
                n_wr_on  = r_issue;
                n_wr_col = r_col;
                if (r_wr_on) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_dst, r_wr_col};
                    ram_wdata = ram_rdata;
                end
                if (!r_issue && r_wr_on) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

endmodule

`default_nettype wire

[hw/rtl/kmp_dfa_string_matcher.sv]
// channel   direction  handshake            payload
// ------------------------------------------------------------------
// item      in         start & !busy        i_item   (opcode, byte_value)
// result    out        o_result_strobe      o_result (match_found, match_start)
//
// Text bytes run at one per cycle while the back part is idle; the result strobe for a
// byte follows the queue stage, the registered table read and the result register.
// An append copies a whole table row in the back part (through the single table read
// port); the first append after a clear also rebuilds the start row before the copy.
// busy is high in reset and while the two-entry queue is full.
// Reset clears the automaton registers; table contents are undefined until built.
// The receiver cannot stall: each result strobe lasts exactly one cycle.

`default_nettype none

module kmp_dfa_string_matcher #(
    parameter int MAX_PATTERN   = kdm_pkg::MAX_PATTERN_DEF,
    parameter int ALPHABET      = kdm_pkg::ALPHABET_DEF,
    parameter int POSITION_BITS = kdm_pkg::POSITION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire kdm_pkg::t_in_item i_item,
    output logic                   busy,
    output logic                   o_result_strobe,
    output kdm_pkg::t_out_item     o_result
);

    import kdm_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd front_cmd;
    t_cmd back_cmd;

    // front: accept and classify
    kdm_front #(
        .ALPHABET (ALPHABET)
    ) u_front (
        .i_start (start),
        .i_item  (i_item),
        .i_full  (busy),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    // command queue
    kdm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: automaton build and text stepping
    kdm_back #(
        .MAX_PATTERN   (MAX_PATTERN),
        .ALPHABET      (ALPHABET),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (back_cmd),
        .i_valid         (!q_empty),
        .o_pop           (pop),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    // no transaction is taken while reset is held or the queue is full
    assign busy = q_full || !i_rst_n;

endmodule

`default_nettype wire
